// ===== src/osfc_pkg.sv =====
// types, codes and coefficient table shared by the observer controller
`timescale 1ns / 1ps

package osfc_pkg;

    localparam int TAB_FRAC = 24;
    localparam int CF_MAX_W = 28;

    typedef struct packed {
        logic signed [31:0] velocity_in;
        logic signed [31:0] position_meas;
        logic signed [31:0] angle_meas;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] control_out;
        logic signed [31:0] position_error;
    } t_out_word;

    // multiplier signal operand
    typedef enum logic [2:0] {
        SIG_Q1,
        SIG_Q2,
        SIG_Q3,
        SIG_VEL,
        SIG_EP,
        SIG_EA
    } t_sig;

    // multiplier coefficient operand
    typedef enum logic [3:0] {
        CF_ONE,
        CF_A22,
        CF_A23,
        CF_A32,
        CF_B2,
        CF_B3,
        CF_L1,
        CF_L2,
        CF_L3,
        CF_NK1,
        CF_NK2,
        CF_NK3
    } t_coef;

    // where a finished accumulation goes
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_N1,
        FIN_N2,
        FIN_N3,
        FIN_U
    } t_fin;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mac;
        t_sig  sig;
        t_coef cf;
        logic  first;
        t_fin  fin;
    } t_cmd;

    // coefficient with 24 fraction bits, rounded half up to frac bits
    function automatic logic signed [CF_MAX_W-1:0] cf_value(input t_coef c, input int frac);
        logic signed [31:0] v;
        int                 s;
        unique case (c)
            CF_ONE:  v = 32'sd16777216;
            CF_A22:  v = 32'sd16844325;
            CF_A23:  v = 32'sd167940;
            CF_A32:  v = 32'sd13733829;
            CF_B2:   v = -32'sd1400059;
            CF_B3:   v = -32'sd571935;
            CF_L1:   v = 32'sd10368319;
            CF_L2:   v = 32'sd10715608;
            CF_L3:   v = 32'sd27467658;
            CF_NK1:  v = 32'sd15112916;
            CF_NK2:  v = 32'sd41461534;
            CF_NK3:  v = 32'sd4269801;
            default: v = 32'sd0;
        endcase
        s = TAB_FRAC - frac;
        if (s > 0) begin
            v = (v + (32'sd1 <<< (s - 1))) >>> s;
        end
        return CF_MAX_W'(v);
    endfunction

endpackage

// ===== src/osfc_ctrl.sv =====
// sequencer for the observer controller: handshakes and multiply-accumulate schedule
`timescale 1ns / 1ps

module osfc_ctrl
    import osfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] LAST_STEP = 4'd15;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       w_in_acc;
    logic       w_out_free;

    assign o_in_ready  = (r_state == ST_IDLE) || (r_state == ST_FIN);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (r_step != LAST_STEP) begin
                    n_step = r_step + 4'd1;
                end else if (w_out_free) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == ST_FIN) begin
            n_out_valid = 1'b1;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.sig   = SIG_Q1;
        o_cmd.cf    = CF_ONE;
        o_cmd.fin   = FIN_NONE;
        o_cmd.load  = w_in_acc;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                4'd0:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q1;  o_cmd.cf = CF_ONE;
                             o_cmd.first = 1'b1; end
                4'd1:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_EP;  o_cmd.cf = CF_L1;  end
                4'd2:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q2;  o_cmd.cf = CF_A22;
                             o_cmd.first = 1'b1; o_cmd.fin = FIN_N1; end
                4'd3:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q3;  o_cmd.cf = CF_A23; end
                4'd4:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_VEL; o_cmd.cf = CF_B2;  end
                4'd5:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_EA;  o_cmd.cf = CF_L2;  end
                4'd6:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q2;  o_cmd.cf = CF_A32;
                             o_cmd.first = 1'b1; o_cmd.fin = FIN_N2; end
                4'd7:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q3;  o_cmd.cf = CF_A22; end
                4'd8:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_VEL; o_cmd.cf = CF_B3;  end
                4'd9:  begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_EA;  o_cmd.cf = CF_L3;  end
                4'd10: begin o_cmd.fin = FIN_N3; end
                4'd11: begin end
                4'd12: begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q1;  o_cmd.cf = CF_NK1;
                             o_cmd.first = 1'b1; end
                4'd13: begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q2;  o_cmd.cf = CF_NK2; end
                4'd14: begin o_cmd.mac = 1'b1; o_cmd.sig = SIG_Q3;  o_cmd.cf = CF_NK3; end
                4'd15: begin
                    if (w_out_free) begin
                        o_cmd.fin = FIN_U;
                    end
                end
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/osfc_dpath.sv =====
// datapath of the observer controller: shared multiplier, accumulator and estimates
`timescale 1ns / 1ps

module osfc_dpath
    import osfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_in_word,
    output t_out_word o_out_word
);

    localparam int CW    = FRAC_BITS + 3;
    localparam int PW    = 32 + CW;
    localparam int ACC_W = PW + 3;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] MAXV  = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [ACC_W-1:0] MINV  = {{(ACC_W-32){1'b1}}, 32'h8000_0000};
    localparam logic signed [32:0]      MAX33 = 33'sh0_7fff_ffff;
    localparam logic signed [32:0]      MIN33 = -33'sh0_8000_0000;

    logic signed [31:0]       r_vel, r_ep, r_ea;
    logic signed [31:0]       r_q1, r_q2, r_q3, r_n2;
    logic signed [PW-1:0]     r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_mac_d, r_first_d;
    t_fin                     r_fin_d;
    t_out_word                r_out;

    logic signed [31:0]         w_sig;
    logic signed [CF_MAX_W-1:0] w_cf_full;
    logic signed [CW-1:0]       w_cf;
    logic signed [PW-1:0]       n_prod;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    w_shift;
    logic signed [31:0]         w_fin;
    logic signed [32:0]         w_dp, w_da;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
        if (d > MAX33) begin
            return 32'sh7fff_ffff;
        end else if (d < MIN33) begin
            return -32'sh8000_0000;
        end
        return d[31:0];
    endfunction

    // operand select and product
    always_comb begin
        unique case (i_cmd.sig)
            SIG_Q1:  w_sig = r_q1;
            SIG_Q2:  w_sig = r_q2;
            SIG_Q3:  w_sig = r_q3;
            SIG_VEL: w_sig = r_vel;
            SIG_EP:  w_sig = r_ep;
            SIG_EA:  w_sig = r_ea;
            default: w_sig = r_q1;
        endcase
    end

    assign w_cf_full = cf_value(i_cmd.cf, FRAC_BITS);
    assign w_cf      = w_cf_full[CW-1:0];
    assign n_prod    = PW'(w_sig) * PW'(w_cf);

    // rounding half is seeded on the first term of each sum
    assign n_acc   = (r_first_d ? HALF : r_acc) + ACC_W'(r_prod);
    assign w_shift = r_acc >>> FRAC_BITS;
    always_comb begin
        if (w_shift > MAXV) begin
            w_fin = 32'sh7fff_ffff;
        end else if (w_shift < MINV) begin
            w_fin = -32'sh8000_0000;
        end else begin
            w_fin = w_shift[31:0];
        end
    end

    assign w_dp = 33'(i_in_word.position_meas) - 33'(r_q1);
    assign w_da = 33'(i_in_word.angle_meas) - 33'(r_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1      <= '0;
            r_q2      <= '0;
            r_q3      <= '0;
            r_mac_d   <= 1'b0;
            r_first_d <= 1'b0;
            r_fin_d   <= FIN_NONE;
        end else begin
            r_mac_d   <= i_cmd.mac;
            r_first_d <= i_cmd.first;
            r_fin_d   <= i_cmd.fin;
            unique case (r_fin_d)
                FIN_N1: r_q1 <= w_fin;
                FIN_N3: begin
                    r_q2 <= r_n2;
                    r_q3 <= w_fin;
                end
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vel <= i_in_word.velocity_in;
            r_ep  <= sat33(w_dp);
            r_ea  <= sat33(w_da);
        end
        r_prod <= n_prod;
        if (r_mac_d) begin
            r_acc <= n_acc;
        end
        if (r_fin_d == FIN_N2) begin
            r_n2 <= w_fin;
        end
        if (r_fin_d == FIN_U) begin
            r_out.control_out    <= w_fin;
            r_out.position_error <= r_ep;
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== src/observer_state_feedback_controller.sv =====
// top level of the observer-based state-feedback controller
// result word: valid as it enters the output register, after the last step and the FIN state
// one word at a time: the 16-step schedule runs on one shared multiplier
// a new input word is taken while idle or in the cycle the previous result is written to the output register
// a result that is not taken holds the schedule on its last step
// reset: synchronous active low, clears the three estimates and all handshake state
`timescale 1ns / 1ps

module observer_state_feedback_controller
    import osfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // command word from the sequencer to the datapath
    t_cmd w_cmd;

    // sequencer: input accept loads operands and errors, then 16 steps
    // issue the observer and feedback products; the last step writes the
    // result word once the output register is free
    osfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // datapath: one registered multiplier feeding one accumulator,
    // round and saturate on the way into the estimates and the result
    osfc_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

// ===== src/osfc_chk.sv =====
// port-level checks for the observer controller and their binding
`timescale 1ns / 1ps

module osfc_chk
    import osfc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("stalled result word changed");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accept");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("handshake not cleared by reset");

endmodule

bind observer_state_feedback_controller osfc_chk u_osfc_chk (.*);
